@@ rtl/ils_pkg.sv @@
`timescale 1ns / 1ps

package ils_pkg;

  localparam int CAPACITY   = 1024;
  localparam int ELEM_WIDTH = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  localparam int MODE_W   = 3;
  localparam int POS_W    = 10;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  typedef enum logic [MODE_W-1:0] {
    M_GET    = 3'd0,
    M_SET    = 3'd1,
    M_PUSH   = 3'd2,
    M_POP    = 3'd3,
    M_INSERT = 3'd4,
    M_REMOVE = 3'd5,
    M_CLEAR  = 3'd6
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SHIFT_UP,
    S_INS_WR,
    S_RM_FIRST,
    S_SHIFT_DN,
    S_EMIT
  } state_t;

  typedef struct packed {
    status_t status;
    logic    ok;
  } decision_t;

endpackage

@@ rtl/indexed_list_store.sv @@
`timescale 1ns / 1ps

// Ordered list of up to CAPACITY elements held in a single-port-write,
// registered-read memory, with one request in flight at a time. Set, push,
// clear, an ignored mode, insert at the end of the list and every failing
// request go from accept straight to the result state; get and pop go
// via a read state first because of the registered memory read. Insert at a
// position p below the count n shifts the tail up, then writes the new
// element, and remove shifts the tail down; the tail is moved one entry per
// cycle through the memory (one read and one write each cycle). in_ready is
// high only while no request is in progress; a finished result sits in the
// output register and a new request may be accepted while it waits there.
module indexed_list_store (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ils_pkg::MODE_W-1:0]   mode,
  input  logic [ils_pkg::POS_W-1:0]    position,
  input  logic [ils_pkg::DATA_W-1:0]   elem_in,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ils_pkg::STATUS_W-1:0] status,
  output logic [ils_pkg::DATA_W-1:0]   elem_out,
  output logic [ils_pkg::POS_W-1:0]    pushed_at,
  output logic [ils_pkg::CNT_W-1:0]    count_now
);

  localparam int AW = ils_pkg::ADDR_W;
  localparam int CW = ils_pkg::CNT_W;
  localparam int EW = ils_pkg::ELEM_WIDTH;

  logic [EW-1:0] mem [ils_pkg::CAPACITY];
  logic [EW-1:0] rdata;

  ils_pkg::state_t    state, state_next;
  ils_pkg::decision_t dec;
  ils_pkg::mode_t     in_mode;

  logic [CW-1:0]  count, count_next;
  logic [CW-1:0]  ptr, ptr_next;
  logic [CW-1:0]  pos_q;
  logic [EW-1:0]  elem_q;

  ils_pkg::status_t          res_status;
  logic [ils_pkg::DATA_W-1:0] res_elem;
  logic [ils_pkg::POS_W-1:0]  res_pushed;
  logic [CW-1:0]              res_count;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [EW-1:0] wr_data;
  logic          accept, emit;

  assign in_mode  = ils_pkg::mode_t'(mode);
  assign in_ready = (state == ils_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign emit     = (state == ils_pkg::S_EMIT) && (!out_valid || out_ready);

  ils_check u_check (
    .mode     (mode),
    .position (position),
    .count    (count),
    .dec      (dec)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ils_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = ils_pkg::S_EMIT;
          if (dec.ok) begin
            case (in_mode)
              ils_pkg::M_GET, ils_pkg::M_POP: state_next = ils_pkg::S_READ;
              ils_pkg::M_INSERT: begin
                if (CW'(position) != count) state_next = ils_pkg::S_SHIFT_UP;
              end
              ils_pkg::M_REMOVE: state_next = ils_pkg::S_RM_FIRST;
              default: state_next = ils_pkg::S_EMIT;
            endcase
          end
        end
      end
      ils_pkg::S_READ:     state_next = ils_pkg::S_EMIT;
      ils_pkg::S_SHIFT_UP: begin
        if (ptr == pos_q) state_next = ils_pkg::S_INS_WR;
      end
      ils_pkg::S_INS_WR:   state_next = ils_pkg::S_EMIT;
      ils_pkg::S_RM_FIRST: begin
        state_next = (ptr < count) ? ils_pkg::S_SHIFT_DN : ils_pkg::S_EMIT;
      end
      ils_pkg::S_SHIFT_DN: begin
        if (!(ptr + CW'(1) < count)) state_next = ils_pkg::S_EMIT;
      end
      ils_pkg::S_EMIT: begin
        if (!out_valid || out_ready) state_next = ils_pkg::S_IDLE;
      end
      default: state_next = ils_pkg::S_IDLE;
    endcase
  end

  // memory controls, pointer and count
  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = elem_in[EW-1:0];
    ptr_next   = ptr;
    count_next = count;
    case (state)
      ils_pkg::S_IDLE: begin
        if (in_valid && dec.ok) begin
          case (in_mode)
            ils_pkg::M_GET: begin
              rd_en   = 1'b1;
              rd_addr = position[AW-1:0];
            end
            ils_pkg::M_SET: begin
              wr_en   = 1'b1;
              wr_addr = position[AW-1:0];
            end
            ils_pkg::M_PUSH: begin
              wr_en      = 1'b1;
              wr_addr    = count[AW-1:0];
              count_next = count + CW'(1);
            end
            ils_pkg::M_POP: begin
              rd_en      = 1'b1;
              rd_addr    = AW'(count - CW'(1));
              count_next = count - CW'(1);
            end
            ils_pkg::M_INSERT: begin
              count_next = count + CW'(1);
              if (CW'(position) == count) begin
                wr_en   = 1'b1;
                wr_addr = position[AW-1:0];
              end else begin
                rd_en    = 1'b1;
                rd_addr  = AW'(count - CW'(1));
                ptr_next = count - CW'(1);
              end
            end
            ils_pkg::M_REMOVE: begin
              rd_en      = 1'b1;
              rd_addr    = position[AW-1:0];
              ptr_next   = CW'(position);
              count_next = count - CW'(1);
            end
            ils_pkg::M_CLEAR: count_next = '0;
            default: count_next = count;
          endcase
        end
      end
      ils_pkg::S_SHIFT_UP: begin
        wr_en   = 1'b1;
        wr_addr = AW'(ptr + CW'(1));
        wr_data = rdata;
        if (ptr != pos_q) begin
          rd_en    = 1'b1;
          rd_addr  = AW'(ptr - CW'(1));
          ptr_next = ptr - CW'(1);
        end
      end
      ils_pkg::S_INS_WR: begin
        wr_en   = 1'b1;
        wr_addr = pos_q[AW-1:0];
        wr_data = elem_q;
      end
      ils_pkg::S_RM_FIRST: begin
        rd_en   = 1'b1;
        rd_addr = AW'(ptr + CW'(1));
      end
      ils_pkg::S_SHIFT_DN: begin
        wr_en   = 1'b1;
        wr_addr = ptr[AW-1:0];
        wr_data = rdata;
        if (ptr + CW'(1) < count) begin
          rd_en    = 1'b1;
          rd_addr  = AW'(ptr + CW'(2));
          ptr_next = ptr + CW'(1);
        end
      end
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ils_pkg::S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    if (accept) begin
      pos_q      <= CW'(position);
      elem_q     <= elem_in[EW-1:0];
      res_status <= dec.status;
      res_elem   <= '0;
      res_pushed <= (dec.ok && in_mode == ils_pkg::M_PUSH) ? count[AW-1:0] : '0;
      res_count  <= count_next;
    end
    if (state == ils_pkg::S_READ || state == ils_pkg::S_RM_FIRST) begin
      res_elem <= ils_pkg::DATA_W'(rdata);
    end
    if (emit) begin
      status    <= res_status;
      elem_out  <= res_elem;
      pushed_at <= res_pushed;
      count_now <= res_count;
    end
  end

endmodule

@@ rtl/ils_check.sv @@
`timescale 1ns / 1ps

module ils_check (
  input  logic [ils_pkg::MODE_W-1:0] mode,
  input  logic [ils_pkg::POS_W-1:0]  position,
  input  logic [ils_pkg::CNT_W-1:0]  count,
  output ils_pkg::decision_t         dec
);

  logic [ils_pkg::CNT_W-1:0] pos_ext;
  logic                      full;
  ils_pkg::status_t          st;

  assign pos_ext = ils_pkg::CNT_W'(position);
  assign full    = (count >= ils_pkg::CNT_W'(ils_pkg::CAPACITY));

  always_comb begin
    st = ils_pkg::ST_OK;
    case (mode)
      ils_pkg::M_GET, ils_pkg::M_SET, ils_pkg::M_REMOVE: begin
        if (pos_ext >= count) st = ils_pkg::ST_RANGE;
      end
      ils_pkg::M_PUSH: begin
        if (full) st = ils_pkg::ST_FULL;
      end
      ils_pkg::M_POP: begin
        if (count == '0) st = ils_pkg::ST_EMPTY;
      end
      ils_pkg::M_INSERT: begin
        if (pos_ext > count) st = ils_pkg::ST_RANGE;
        else if (full) st = ils_pkg::ST_FULL;
      end
      default: st = ils_pkg::ST_OK;
    endcase
  end

  assign dec.status = st;
  assign dec.ok     = (st == ils_pkg::ST_OK);

endmodule

@@ rtl/ils_chk.sv @@
`timescale 1ns / 1ps

module ils_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [ils_pkg::STATUS_W-1:0] status,
  input logic [ils_pkg::DATA_W-1:0]   elem_out,
  input logic [ils_pkg::POS_W-1:0]    pushed_at,
  input logic [ils_pkg::CNT_W-1:0]    count_now
);

  localparam logic [ils_pkg::CNT_W-1:0] CAP = ils_pkg::CNT_W'(ils_pkg::CAPACITY);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(elem_out)
      && $stable(pushed_at) && $stable(count_now))
    else $error("result beat changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ils_pkg::ST_OK |-> elem_out == '0 && pushed_at == '0)
    else $error("failed request carries data");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> count_now <= CAP)
    else $error("count above capacity");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ils_pkg::ST_EMPTY |-> count_now == '0)
    else $error("empty status with elements held");

  a_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ils_pkg::ST_FULL |-> count_now == CAP)
    else $error("full status on a list not full");

endmodule

bind indexed_list_store ils_chk u_ils_chk (.*);
